[sv/rph_pkg.sv]
// Package for the radio pairing handshake: item layouts, register indexes,
// message and phase codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rph_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID           = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOVER_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_INTERVAL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_TIMEOUT    = 2'd3;

    localparam logic [7:0]  RESET_SELF_ID   = 8'd1;
    localparam logic [15:0] RESET_DISCOVER  = 16'd250;
    localparam logic [15:0] RESET_CONFIRM   = 16'd250;
    localparam logic [15:0] RESET_TIMEOUT   = 16'd2000;
    localparam logic [7:0]  RESPONDER_ID    = 8'd2;
    localparam logic [15:0] SINCE_TX_MAX    = 16'hFFFF;
    localparam logic [5:0]  PACKET_LEN      = 6'd4;
    localparam logic [7:0]  BROADCAST_ID    = 8'd0;

    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_RX      = 2'd1;
    localparam logic [1:0] MODE_TX_DONE = 2'd2;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    localparam logic [7:0] T_DISCOVER  = 8'd1;
    localparam logic [7:0] T_OFFER     = 8'd2;
    localparam logic [7:0] T_CONFIRM   = 8'd3;
    localparam logic [7:0] T_CONFIRMED = 8'd4;

    localparam logic [1:0] PH_SEARCH         = 2'd0;
    localparam logic [1:0] PH_WAIT_OFFER     = 2'd1;
    localparam logic [1:0] PH_WAIT_CONFIRMED = 2'd2;
    localparam logic [1:0] PH_PAIRED         = 2'd3;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    typedef struct packed {
        logic [7:0]  self_id;
        logic [15:0] discover_interval;
        logic [15:0] confirm_interval;
        logic [15:0] search_timeout;
    } rph_cfg_t;

    // Packed from the top down, so ack_present is the highest bit of tdata.
    typedef struct packed {
        logic        ack_present;
        logic        tx_ok;
        logic [5:0]  payload_len;
        logic [7:0]  msg_to;
        logic [7:0]  msg_from;
        logic [7:0]  msg_type;
    } rph_item_t;

    typedef struct packed {
        logic [1:0]  pair_phase;
        logic [7:0]  peer_node;
        logic        is_paired;
        logic        listen_dedicated;
        logic [7:0]  ack_dest;
        logic [2:0]  ack_type;
        logic        ack_queue;
        logic [7:0]  send_dest;
        logic [2:0]  send_type;
        logic        send_request;
    } rph_result_t;

endpackage

`default_nettype wire

[sv/rph_cfg.sv]
// Configuration register file of the pairing handshake.
// Depends on rph_pkg for register indexes and reset values.
`timescale 1ns / 1ps
`default_nettype none

module rph_cfg
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [rph_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rph_pkg::CFG_DATA_W-1:0] cfg_data,
    output rph_pkg::rph_cfg_t                   cfg
);

    rph_pkg::rph_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.self_id           <= rph_pkg::RESET_SELF_ID;
            cfg_reg.discover_interval <= rph_pkg::RESET_DISCOVER;
            cfg_reg.confirm_interval  <= rph_pkg::RESET_CONFIRM;
            cfg_reg.search_timeout    <= rph_pkg::RESET_TIMEOUT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rph_pkg::CFG_SELF_ID:           cfg_reg.self_id <= cfg_data[7:0];
                rph_pkg::CFG_DISCOVER_INTERVAL: cfg_reg.discover_interval <= cfg_data;
                rph_pkg::CFG_CONFIRM_INTERVAL:  cfg_reg.confirm_interval <= cfg_data;
                rph_pkg::CFG_SEARCH_TIMEOUT:    cfg_reg.search_timeout <= cfg_data;
                default:                        cfg_reg.self_id <= cfg_reg.self_id;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[sv/rph_fsm.sv]
// Pairing state and next-state logic: works out the result of one event from
// the current state and commits the new state when the item moves on.
// Depends on rph_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rph_fsm
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [1:0]            mode,
    input  wire rph_pkg::rph_item_t    item,
    input  wire rph_pkg::rph_cfg_t     cfg,
    output rph_pkg::rph_result_t       res
);

    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  peer_reg, peer_next;
    logic        paired_reg, paired_next;
    logic [15:0] since_tx_reg, since_tx_next;
    logic        awaiting_reg, awaiting_next;

    logic        responder;
    logic        len_ok;
    logic [15:0] since_inc;
    logic        fire;

    assign responder = (cfg.self_id == rph_pkg::RESPONDER_ID);
    assign len_ok    = (item.payload_len == rph_pkg::PACKET_LEN);
    assign since_inc = (since_tx_reg == rph_pkg::SINCE_TX_MAX) ? since_tx_reg
                                                                : since_tx_reg + 16'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        peer_next     = peer_reg;
        paired_next   = paired_reg;
        since_tx_next = since_tx_reg;
        awaiting_next = awaiting_reg;
        fire          = 1'b0;
        res           = '0;

        unique case (mode)
            rph_pkg::MODE_TICK:
            begin
                since_tx_next = since_inc;
                if (!responder && phase_reg == rph_pkg::PH_SEARCH)
                begin
                    if (since_inc >= cfg.discover_interval)
                    begin
                        res.send_request = 1'b1;
                        res.send_type    = rph_pkg::T_DISCOVER[2:0];
                        res.send_dest    = rph_pkg::BROADCAST_ID;
                        since_tx_next    = '0;
                        awaiting_next    = 1'b1;
                    end
                end
                else if (!responder && phase_reg == rph_pkg::PH_WAIT_CONFIRMED)
                begin
                    fire = (since_inc >= cfg.confirm_interval);
                    if (fire)
                    begin
                        res.send_request = 1'b1;
                        res.send_type    = rph_pkg::T_CONFIRM[2:0];
                        res.send_dest    = peer_reg;
                        since_tx_next    = '0;
                        awaiting_next    = 1'b1;
                    end
                    // The timeout is judged only when no transmit fires, on the incremented count.
                    if (!fire && since_inc > cfg.search_timeout)
                    begin
                        phase_next = rph_pkg::PH_SEARCH;
                        peer_next  = '0;
                    end
                end
            end
            rph_pkg::MODE_RX:
            begin
                if (responder && len_ok)
                begin
                    if (item.msg_type == rph_pkg::T_DISCOVER &&
                        item.msg_to == rph_pkg::BROADCAST_ID)
                    begin
                        peer_next            = item.msg_from;
                        res.ack_queue        = 1'b1;
                        res.ack_type         = rph_pkg::T_OFFER[2:0];
                        res.ack_dest         = item.msg_from;
                        res.listen_dedicated = 1'b1;
                    end
                    else if (item.msg_type == rph_pkg::T_CONFIRM &&
                             item.msg_to == cfg.self_id)
                    begin
                        peer_next     = item.msg_from;
                        res.ack_queue = 1'b1;
                        res.ack_type  = rph_pkg::T_CONFIRMED[2:0];
                        res.ack_dest  = item.msg_from;
                        if (!paired_reg)
                        begin
                            paired_next = 1'b1;
                            phase_next  = rph_pkg::PH_PAIRED;
                        end
                    end
                end
            end
            rph_pkg::MODE_TX_DONE:
            begin
                if (!responder && awaiting_reg)
                begin
                    awaiting_next = 1'b0;
                    if (item.tx_ok && item.ack_present && len_ok &&
                        item.msg_to == cfg.self_id)
                    begin
                        if (phase_reg == rph_pkg::PH_SEARCH &&
                            item.msg_type == rph_pkg::T_OFFER)
                        begin
                            peer_next  = item.msg_from;
                            phase_next = rph_pkg::PH_WAIT_CONFIRMED;
                        end
                        else if (phase_reg == rph_pkg::PH_WAIT_CONFIRMED &&
                                 item.msg_type == rph_pkg::T_CONFIRMED)
                        begin
                            paired_next = 1'b1;
                            phase_next  = rph_pkg::PH_PAIRED;
                        end
                    end
                end
            end
            rph_pkg::MODE_NONE:
            begin
                awaiting_next = awaiting_reg;
            end
            default:
            begin
                awaiting_next = awaiting_reg;
            end
        endcase

        res.is_paired  = paired_next;
        res.peer_node  = peer_next;
        res.pair_phase = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= rph_pkg::PH_SEARCH;
            peer_reg     <= '0;
            paired_reg   <= 1'b0;
            since_tx_reg <= rph_pkg::SINCE_TX_MAX;
            awaiting_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            peer_reg     <= peer_next;
            paired_reg   <= paired_next;
            since_tx_reg <= since_tx_next;
            awaiting_reg <= awaiting_next;
        end
    end

endmodule

`default_nettype wire

[sv/radio_pairing_handshake.sv]
// Top level of the radio pairing handshake: input register, result register
// and handshakes. Depends on rph_pkg, rph_cfg and rph_fsm.
//
//  channel   direction  handshake              contents
//  s_axis    in         tvalid/tready          one event item
//  m_axis    out        tvalid/tready          one result item per event
//  cfg       in         cfg_we, no wait        register index and data
//
// An item waits in the input register and is resolved against the pairing
// state on its way into the result register. One item can be taken every
// cycle while the result is not stalled; the next-state logic in rph_fsm is
// combinational. Reset returns the pairing state and configuration to their
// reset values and clears the valid flags, not the item or result registers.
// A stalled result holds its register; the input accepts one item behind it.
`timescale 1ns / 1ps
`default_nettype none

module radio_pairing_handshake
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output      logic                           s_axis_tready,
    // msg_type[7:0], msg_from[15:8], msg_to[23:16], payload_len[29:24],
    // tx_ok[30], ack_present[31]
    input  wire logic [rph_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // mode[1:0]
    input  wire logic [1:0]                     s_axis_tuser,
    output      logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // send_request[0], send_type[3:1], send_dest[11:4], ack_queue[12],
    // ack_type[15:13], ack_dest[23:16], listen_dedicated[24], is_paired[25],
    // peer_node[33:26], pair_phase[35:34], zeros[39:36]
    output      logic [rph_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [rph_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rph_pkg::CFG_DATA_W-1:0] cfg_data
);

    rph_pkg::rph_cfg_t    cfg;
    rph_pkg::rph_item_t   item_reg;
    logic [1:0]           mode_reg;
    logic                 in_valid_reg;
    rph_pkg::rph_result_t res;
    rph_pkg::rph_result_t res_reg;
    logic                 out_valid_reg;
    logic                 advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    rph_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rph_fsm u_fsm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .mode  (mode_reg),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg <= s_axis_tdata;
            mode_reg <= s_axis_tuser;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, res_reg};

    // A paired flag and the paired phase always travel together.
    a_paired_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (res_reg.is_paired == (res_reg.pair_phase == rph_pkg::PH_PAIRED)))
        else $error("paired flag and phase disagree");

    // A result never both requests a transmit and queues an ack payload.
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(res_reg.send_request && res_reg.ack_queue))
        else $error("transmit and ack payload in one result");

    // Transmit requests carry only discover or confirm.
    a_send_type: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res_reg.send_request) |->
            (res_reg.send_type == rph_pkg::T_DISCOVER[2:0] ||
             res_reg.send_type == rph_pkg::T_CONFIRM[2:0]))
        else $error("bad transmit type");

    // An item moved on in one cycle shows up as a result in the next.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("result lost after advance");

endmodule

`default_nettype wire
